>>> hw/rtl/gpl_pkg.sv
// ----------------------------------------------------------------------------
// gpl_pkg
// shared types, register codes and mask helpers for the 16-pin gpio port
// ----------------------------------------------------------------------------
`default_nettype none

package gpl_pkg;

  localparam int PINS = 16;
  localparam logic [15:0] PIN_MASK = 16'((32'd1 << PINS) - 32'd1);
  localparam int KEY_BIT = 16;

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  typedef enum logic [3:0] {
    REG_MODE     = 4'd0,
    REG_TYPE     = 4'd1,
    REG_SPEED    = 4'd2,
    REG_PULL     = 4'd3,
    REG_INPUT    = 4'd4,
    REG_OUTPUT   = 4'd5,
    REG_SETRESET = 4'd6,
    REG_LOCK     = 4'd7,
    REG_ALTLOW   = 4'd8,
    REG_ALTHIGH  = 4'd9
  } reg_sel_t;

  typedef enum logic [2:0] {
    SEQ_IDLE = 3'b001,
    SEQ_ONE  = 3'b010,
    SEQ_TWO  = 3'b100
  } lock_seq_t;

  typedef struct packed {
    logic        req_type;
    logic [3:0]  reg_sel;
    logic [31:0] write_data;
    logic [15:0] pin_levels;
  } gpl_in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [15:0] pin_drive;
    logic        lock_active;
    logic        bad_access;
  } gpl_out_t;

  // one bit per pin
  function automatic logic [31:0] spread1(input logic [15:0] m);
    return {16'd0, m};
  endfunction

  // two bits per pin
  function automatic logic [31:0] spread2(input logic [15:0] m);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      r[2*i +: 2] = {2{m[i]}};
    end
    return r;
  endfunction

  // four bits per pin, eight pins
  function automatic logic [31:0] spread4(input logic [7:0] m);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r[4*i +: 4] = {4{m[i]}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/gpio_port_with_config_lock_core.sv
// ----------------------------------------------------------------------------
// gpio_port_with_config_lock_core
// register interface of a 16-pin gpio port with a lock key sequence
// ----------------------------------------------------------------------------
// each input transaction is one register access (read or write of mode,
// type, speed, pull, input, output, setreset, lock, altlow or althigh).
// every access gives exactly one result transaction holding the read value,
// the output latch after the access, the lock state and a bad access flag.
// both channels use valid/ready. the access is decoded and applied to the
// register file in the cycle it is accepted; the result is registered and
// shown on out_*. throughput is one access per cycle while out_ready is
// high. a result register plus a skid register part the two sides: with
// the receiver stalled one further access is still taken, then in_ready
// drops until a result is delivered.
// synchronous active-low reset clears all configuration, the output latch,
// the lock and both result slots.
// ----------------------------------------------------------------------------
`default_nettype none

module gpio_port_with_config_lock_core
  import gpl_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire gpl_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output gpl_out_t      out_data
);

  logic [31:0] mode_r, speed_r, pull_r, altlo_r, althi_r;
  logic [15:0] type_r, latch_r, lmask_r;
  logic        lkey_r;
  lock_seq_t   lseq_r;

  logic [31:0] mode_nxt, speed_nxt, pull_nxt, altlo_nxt, althi_nxt;
  logic [15:0] type_nxt, latch_nxt, lmask_nxt;
  logic        lkey_nxt;
  lock_seq_t   lseq_nxt;

  gpl_out_t    res, out_r, skid_r;
  logic        out_vld_r, skid_vld_r;
  logic        acc;

  logic [15:0] kmask;
  logic [31:0] cur, vmask, kept, gval;
  logic        gblk;
  logic        key;
  logic [15:0] wmask;
  logic [15:0] wd_hi;

  assign acc      = in_valid && in_ready;
  assign in_ready = !skid_vld_r;
  assign kmask    = lkey_r ? (lmask_r & PIN_MASK) : 16'd0;
  assign key      = in_data.write_data[KEY_BIT];
  assign wmask    = in_data.write_data[15:0] & PIN_MASK;
  assign wd_hi    = in_data.write_data[31:16];

  // guarded write of the selected configuration register
  always_comb begin
    cur   = '0;
    vmask = '0;
    kept  = '0;
    case (in_data.reg_sel)
      REG_MODE: begin
        cur = mode_r; vmask = spread2(PIN_MASK); kept = spread2(kmask);
      end
      REG_TYPE: begin
        cur = {16'd0, type_r}; vmask = spread1(PIN_MASK); kept = spread1(kmask);
      end
      REG_SPEED: begin
        cur = speed_r; vmask = spread2(PIN_MASK); kept = spread2(kmask);
      end
      REG_PULL: begin
        cur = pull_r; vmask = spread2(PIN_MASK); kept = spread2(kmask);
      end
      REG_ALTLOW: begin
        cur = altlo_r; vmask = spread4(PIN_MASK[7:0]); kept = spread4(kmask[7:0]);
      end
      REG_ALTHIGH: begin
        cur = althi_r; vmask = spread4(PIN_MASK[15:8]); kept = spread4(kmask[15:8]);
      end
      default: begin
        cur = '0;
      end
    endcase
    gblk = |((cur ^ in_data.write_data) & vmask & kept);
    gval = (cur & kept) | (in_data.write_data & vmask & ~kept);
  end

  always_comb begin
    mode_nxt  = mode_r;
    type_nxt  = type_r;
    speed_nxt = speed_r;
    pull_nxt  = pull_r;
    altlo_nxt = altlo_r;
    althi_nxt = althi_r;
    latch_nxt = latch_r;
    lmask_nxt = lmask_r;
    lkey_nxt  = lkey_r;
    lseq_nxt  = lseq_r;
    res       = '0;
    if (in_data.req_type == REQ_WRITE) begin
      case (in_data.reg_sel)
        REG_MODE:     begin mode_nxt  = gval;        res.bad_access = gblk; end
        REG_TYPE:     begin type_nxt  = gval[15:0];  res.bad_access = gblk; end
        REG_SPEED:    begin speed_nxt = gval;        res.bad_access = gblk; end
        REG_PULL:     begin pull_nxt  = gval;        res.bad_access = gblk; end
        REG_ALTLOW:   begin altlo_nxt = gval;        res.bad_access = gblk; end
        REG_ALTHIGH:  begin althi_nxt = gval;        res.bad_access = gblk; end
        REG_INPUT:    res.bad_access = 1'b1;
        REG_OUTPUT:   latch_nxt = in_data.write_data[15:0] & PIN_MASK;
        REG_SETRESET: begin
          latch_nxt = ((latch_r & ~wd_hi) | in_data.write_data[15:0]) & PIN_MASK;
        end
        REG_LOCK: begin
          if (lkey_r) begin
            res.bad_access = 1'b1;
          end else if (lseq_r == SEQ_ONE && !key && wmask == lmask_r) begin
            lseq_nxt = SEQ_TWO;
          end else if (lseq_r == SEQ_TWO && key && wmask == lmask_r) begin
            lkey_nxt = 1'b1;
            lseq_nxt = SEQ_IDLE;
          end else begin
            lmask_nxt = wmask;
            lseq_nxt  = key ? SEQ_ONE : SEQ_IDLE;
          end
        end
        default: res.bad_access = 1'b0;
      endcase
    end else begin
      case (in_data.reg_sel)
        REG_MODE:    res.read_data = mode_r;
        REG_TYPE:    res.read_data = {16'd0, type_r};
        REG_SPEED:   res.read_data = speed_r;
        REG_PULL:    res.read_data = pull_r;
        REG_INPUT:   res.read_data = {16'd0, in_data.pin_levels & PIN_MASK};
        REG_OUTPUT:  res.read_data = {16'd0, latch_r};
        REG_LOCK:    res.read_data = {15'd0, lkey_r, lmask_r};
        REG_ALTLOW:  res.read_data = altlo_r;
        REG_ALTHIGH: res.read_data = althi_r;
        default:     res.read_data = '0;
      endcase
    end
    res.pin_drive   = latch_nxt;
    res.lock_active = lkey_nxt;
  end

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= '0;
      type_r  <= '0;
      speed_r <= '0;
      pull_r  <= '0;
      altlo_r <= '0;
      althi_r <= '0;
      latch_r <= '0;
      lmask_r <= '0;
      lkey_r  <= 1'b0;
      lseq_r  <= SEQ_IDLE;
    end else if (acc) begin
      mode_r  <= mode_nxt;
      type_r  <= type_nxt;
      speed_r <= speed_nxt;
      pull_r  <= pull_nxt;
      altlo_r <= altlo_nxt;
      althi_r <= althi_nxt;
      latch_r <= latch_nxt;
      lmask_r <= lmask_nxt;
      lkey_r  <= lkey_nxt;
      lseq_r  <= lseq_nxt;
    end
  end

  // result register and skid slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (!out_vld_r || out_ready) begin
        if (skid_vld_r) begin
          out_vld_r  <= 1'b1;
          skid_vld_r <= 1'b0;
        end else begin
          out_vld_r  <= acc;
        end
      end else if (acc) begin
        skid_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld_r || out_ready) begin
      if (skid_vld_r) begin
        out_r <= skid_r;
      end else if (acc) begin
        out_r <= res;
      end
    end else if (acc) begin
      skid_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

>>> hw/rtl/gpl_checker.sv
// ----------------------------------------------------------------------------
// gpl_checker
// port-level checks for the gpio port core, bound to the core module
// ----------------------------------------------------------------------------
`default_nettype none

module gpl_checker
  import gpl_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_ready,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire gpl_out_t out_data
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // the lock is sticky until reset
  a_lock_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.lock_active |=> !out_valid || out_data.lock_active)
    else $error("lock dropped without reset");

  // a bad access is always a write, which reads back zero
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_access |-> out_data.read_data == 32'd0)
    else $error("bad access with read data");

  // back-pressure only once a result is waiting
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no pending result");

endmodule

bind gpio_port_with_config_lock_core gpl_checker u_gpl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
